FILE: rtl/esl_pkg.sv
// ----------------------------------------------------------------------------
// esl_pkg
// Shared widths, register codes and types of the encoder speed filter.
// ----------------------------------------------------------------------------
`default_nettype none

package esl_pkg;

    localparam int BYTE_W   = 8;
    localparam int ANGLE_W  = 14;
    localparam int LIMIT_W  = 15;
    localparam int WEIGHT_W = 8;
    localparam int RATE_W   = 10;
    localparam int SPEED_W  = 26;

    // filter mix before the divide by 255
    localparam int MIX_W = SPEED_W + WEIGHT_W;
    // remainder left after the shift-sum estimate of mix / 255
    localparam int REM_W = 11;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 8'd255;

    // moving average
    localparam int AVG_DEPTH = 10;
    localparam int SUM_W     = SPEED_W + $clog2(AVG_DEPTH);
    localparam logic [SUM_W-1:0] AVG_RECIP = SUM_W'((64'd1 << SUM_W) / AVG_DEPTH);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LPF_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd3641;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd200;
    localparam logic [RATE_W-1:0]   RATE_RESET   = 10'd100;

    typedef struct packed {
        logic [LIMIT_W-1:0]  step_limit;
        logic [WEIGHT_W-1:0] weight;
        logic [RATE_W-1:0]   rate;
    } t_cfg;

    typedef struct packed {
        logic               accepted;
        logic [ANGLE_W-1:0] step;
    } t_task;

endpackage

`default_nettype wire

FILE: rtl/encoder_speed_limit_lpf_average_top.sv
// ----------------------------------------------------------------------------
// encoder_speed_limit_lpf_average_top
// Encoder speed with step limit, first-order low-pass and moving average.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one sensor word per
// transaction as two bytes. The front stage classifies the angle step at once
// and places it in a two-entry queue, so it keeps taking transactions while
// the back stage works and while a result waits at the output.
// Output channel (o_out_valid / i_out_ready) gives one result per input.
// A rejected sample passes from the queue straight to the output register; an
// accepted one goes through the back-stage steps in order (speed multiply,
// filter multiplies and their sum, divide by 255 in three steps, history
// update, divide by the average depth in two steps). The back stage works on one
// sample at a time and pops the next only once its result is loaded.
// The configuration port writes step limit, filter weight and sample rate at
// any edge with i_cfg_we high; write it only while no sample is in flight.
// Reset (synchronous, active low) restores the register defaults, clears the
// stored angle, filter, history and average, and empties the queue.
// When the receiver stalls the result holds; after the queue fills, o_in_ready
// drops until the back stage frees an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_limit_lpf_average_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [esl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [esl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [esl_pkg::BYTE_W-1:0]     i_raw_high_byte,
    input  wire logic [esl_pkg::BYTE_W-1:0]     i_raw_low_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_step_accepted,
    output logic [esl_pkg::ANGLE_W-1:0]         o_angle_step,
    output logic [esl_pkg::SPEED_W-1:0]         o_speed_now,
    output logic [esl_pkg::SPEED_W-1:0]         o_speed_filtered,
    output logic [esl_pkg::SPEED_W-1:0]         o_speed_average
);
    import esl_pkg::*;

    t_cfg  r_cfg;
    logic  w_push;
    t_task w_push_task;
    logic  w_queue_full;
    logic  w_queue_empty;
    logic  w_queue_pop;
    t_task w_queue_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_limit <= LIMIT_RESET;
            r_cfg.weight     <= WEIGHT_RESET;
            r_cfg.rate       <= RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_LIMIT:  r_cfg.step_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_LPF_WEIGHT:  r_cfg.weight     <= i_cfg_data[WEIGHT_W-1:0];
                CFG_SAMPLE_RATE: r_cfg.rate       <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    esl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_raw_high_byte (i_raw_high_byte),
        .i_raw_low_byte  (i_raw_low_byte),
        .i_step_limit    (r_cfg.step_limit),
        .i_queue_full    (w_queue_full),
        .o_push          (w_push),
        .o_push_task     (w_push_task)
    );

    esl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_task (w_push_task),
        .o_full      (w_queue_full),
        .o_empty     (w_queue_empty),
        .i_pop       (w_queue_pop),
        .o_pop_task  (w_queue_task)
    );

    esl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_queue_empty    (w_queue_empty),
        .i_queue_task     (w_queue_task),
        .o_queue_pop      (w_queue_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_step_accepted  (o_step_accepted),
        .o_angle_step     (o_angle_step),
        .o_speed_now      (o_speed_now),
        .o_speed_filtered (o_speed_filtered),
        .o_speed_average  (o_speed_average)
    );

endmodule

`default_nettype wire

FILE: rtl/esl_front.sv
// ----------------------------------------------------------------------------
// esl_front
// Takes sensor samples, forms the angle step and applies the limit filter.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [esl_pkg::BYTE_W-1:0]  i_raw_high_byte,
    input  wire logic [esl_pkg::BYTE_W-1:0]  i_raw_low_byte,
    input  wire logic [esl_pkg::LIMIT_W-1:0] i_step_limit,
    input  wire logic                        i_queue_full,
    output logic                             o_push,
    output esl_pkg::t_task                   o_push_task
);
    import esl_pkg::*;

    logic [ANGLE_W-1:0] r_last_angle;
    logic [ANGLE_W-1:0] w_angle;
    logic [ANGLE_W-1:0] w_step;
    logic               w_pass;

    assign w_angle = {i_raw_high_byte, i_raw_low_byte[BYTE_W-1:2]};
    // forward step, wraps through zero
    assign w_step  = w_angle - r_last_angle;
    assign w_pass  = (w_step != '0) && ({1'b0, w_step} < i_step_limit);

    assign o_in_ready           = !i_queue_full;
    assign o_push               = i_in_valid && !i_queue_full;
    assign o_push_task.accepted = w_pass;
    assign o_push_task.step     = w_pass ? w_step : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
        end else if (o_push && w_pass) begin
            r_last_angle <= w_angle;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/esl_queue.sv
// ----------------------------------------------------------------------------
// esl_queue
// Short first-in first-out queue of classified samples.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  esl_pkg::t_task i_push_task,
    output logic         o_full,
    output logic         o_empty,
    input  wire logic    i_pop,
    output esl_pkg::t_task o_pop_task
);
    import esl_pkg::*;

    t_task             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_task = r_entry[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/esl_back.sv
// ----------------------------------------------------------------------------
// esl_back
// Speed conversion, low-pass filter and moving average, one sample at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  esl_pkg::t_cfg                    i_cfg,
    input  wire logic                        i_queue_empty,
    input  esl_pkg::t_task                   i_queue_task,
    output logic                             o_queue_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_step_accepted,
    output logic [esl_pkg::ANGLE_W-1:0]      o_angle_step,
    output logic [esl_pkg::SPEED_W-1:0]      o_speed_now,
    output logic [esl_pkg::SPEED_W-1:0]      o_speed_filtered,
    output logic [esl_pkg::SPEED_W-1:0]      o_speed_average
);
    import esl_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RAW  = 4'd1;
    localparam logic [3:0] ST_MIX  = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_Q0   = 4'd4;
    localparam logic [3:0] ST_REM  = 4'd5;
    localparam logic [3:0] ST_NOW  = 4'd6;
    localparam logic [3:0] ST_HIST = 4'd7;
    localparam logic [3:0] ST_AVG0 = 4'd8;
    localparam logic [3:0] ST_AVG1 = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]         r_state;
    t_task              r_task;
    logic [SPEED_W-1:0] r_raw;
    logic [MIX_W-1:0]   r_pa;
    logic [MIX_W-1:0]   r_pb;
    logic [MIX_W-1:0]   r_mix;
    logic [SPEED_W-1:0] r_q0;
    logic [REM_W-1:0]   r_rem;
    logic [SPEED_W-1:0] r_now;
    logic [SPEED_W-1:0] r_filt;
    logic [SPEED_W-1:0] r_hist [AVG_DEPTH];
    logic [SUM_W-1:0]   r_sum;
    logic [SPEED_W-1:0] r_aq;
    logic [SPEED_W-1:0] r_avg;

    logic [ANGLE_W+RATE_W-1:0] w_steprate;
    logic [MIX_W-1:0]          w_q0_sum;
    logic [MIX_W-1:0]          w_q0_x255;
    logic [MIX_W-1:0]          w_rem;
    logic [REM_W:0]            w_fix;
    logic [SPEED_W-1:0]        n_now;
    logic [2*SUM_W-1:0]        w_aprod;
    logic [SUM_W-1:0]          w_aqd;
    logic [SUM_W-1:0]          w_arem;
    logic                      w_out_free;

    assign w_steprate = (ANGLE_W+RATE_W)'(r_task.step) * (ANGLE_W+RATE_W)'(i_cfg.rate);

    // mix / 255 estimated as a sum of shifts, never above the true quotient
    assign w_q0_sum  = (r_mix >> 8) + (r_mix >> 16) + (r_mix >> 24) + (r_mix >> 32);
    assign w_q0_x255 = (MIX_W'(r_q0) << 8) - MIX_W'(r_q0);
    assign w_rem     = r_mix - w_q0_x255;
    // exact small-value divide by 255 of the remainder
    assign w_fix     = ((REM_W+1)'(r_rem) + (REM_W+1)'(1) + (REM_W+1)'(r_rem >> 8)) >> 8;
    assign n_now     = r_q0 + SPEED_W'(w_fix);

    // sum / AVG_DEPTH by reciprocal, at most one short
    assign w_aprod = (2*SUM_W)'(r_sum) * (2*SUM_W)'(AVG_RECIP);
    assign w_aqd   = SUM_W'(r_aq) * SUM_W'(AVG_DEPTH);
    assign w_arem  = r_sum - w_aqd;

    assign w_out_free  = !o_out_valid || i_out_ready;
    assign o_queue_pop = (r_state == ST_IDLE) && !i_queue_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_queue_empty) begin
                        r_state <= i_queue_task.accepted ? ST_RAW : ST_OUT;
                    end
                end
                ST_RAW:  r_state <= ST_MIX;
                ST_MIX:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_Q0;
                ST_Q0:   r_state <= ST_REM;
                ST_REM:  r_state <= ST_NOW;
                ST_NOW:  r_state <= ST_HIST;
                ST_HIST: r_state <= ST_AVG0;
                ST_AVG0: r_state <= ST_AVG1;
                ST_AVG1: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_queue_pop) begin
            r_task <= i_queue_task;
        end
        if (r_state == ST_RAW) begin
            r_raw <= SPEED_W'({w_steprate, 2'b00});
        end
        if (r_state == ST_MIX) begin
            r_pa <= MIX_W'(WEIGHT_FULL - i_cfg.weight) * MIX_W'(r_raw);
            r_pb <= MIX_W'(i_cfg.weight) * MIX_W'(r_filt);
        end
        if (r_state == ST_SUM) begin
            r_mix <= r_pa + r_pb;
        end
        if (r_state == ST_Q0) begin
            r_q0 <= w_q0_sum[SPEED_W-1:0];
        end
        if (r_state == ST_REM) begin
            r_rem <= w_rem[REM_W-1:0];
        end
        if (r_state == ST_AVG0) begin
            r_aq <= w_aprod[SUM_W+SPEED_W-1:SUM_W];
        end
    end

    // filter state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_filt <= '0;
            r_sum  <= '0;
            r_avg  <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (r_state == ST_NOW) begin
                r_now  <= n_now;
                r_filt <= n_now;
            end
            if (r_state == ST_HIST) begin
                r_sum <= r_sum - SUM_W'(r_hist[0]) + SUM_W'(r_now);
                for (int i = 0; i < AVG_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[AVG_DEPTH-1] <= r_now;
            end
            if (r_state == ST_AVG1) begin
                r_avg <= r_aq + SPEED_W'(w_arem >= SUM_W'(AVG_DEPTH));
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            o_step_accepted  <= r_task.accepted;
            o_angle_step     <= r_task.step;
            o_speed_now      <= r_task.accepted ? r_now : '0;
            o_speed_filtered <= r_filt;
            o_speed_average  <= r_avg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/esl_checker.sv
// ----------------------------------------------------------------------------
// esl_checker
// Port-level checks on the encoder speed filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic                           o_step_accepted,
    input  wire logic [esl_pkg::ANGLE_W-1:0]    o_angle_step,
    input  wire logic [esl_pkg::SPEED_W-1:0]    o_speed_now,
    input  wire logic [esl_pkg::SPEED_W-1:0]    o_speed_filtered,
    input  wire logic [esl_pkg::SPEED_W-1:0]    o_speed_average
);

    // a stalled result stays valid and keeps its step, speed and average
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_angle_step)
            && $stable(o_speed_now) && $stable(o_speed_average))
        else $error("result changed while stalled");

    // rejected sample reports no step and no speed
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_step_accepted |-> o_angle_step == '0 && o_speed_now == '0)
        else $error("rejected transaction carries a step or speed");

    // accepted sample has a nonzero step and becomes the filter state
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_accepted |-> o_angle_step != '0
            && o_speed_filtered == o_speed_now)
        else $error("accepted transaction inconsistent with filter state");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind encoder_speed_limit_lpf_average_top esl_checker u_esl_checker (.*);

`default_nettype wire
